FILE: src/sfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_pkg - shared types and constants for the serial frame capture block
// Field widths, register and protocol codes, reset values and the structs
// that pass between the framer and the top level.
// ----------------------------------------------------------------------------
package sfc_pkg;

	localparam int FRAME_LEN_DEF = 25;

	localparam int BYTE_W     = 8;
	localparam int KIND_W     = 2;
	localparam int IDX_W      = 5;
	localparam int PROTO_W    = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SBUS_START  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPORT_START = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_ID     = 2'd3;

	// protocol codes
	localparam logic [PROTO_W-1:0] PROTO_SBUS  = 2'd0;
	localparam logic [PROTO_W-1:0] PROTO_SPORT = 2'd1;
	localparam logic [PROTO_W-1:0] PROTO_RAW   = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_SBUS  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SPORT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RAW   = 2'd2;

	// input mode codes
	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_IDLE = 1'b1;

	// register reset values
	localparam logic [PROTO_W-1:0] PROTOCOL_RST    = PROTO_SBUS;
	localparam logic [BYTE_W-1:0]  SBUS_START_RST  = 8'd15;
	localparam logic [BYTE_W-1:0]  SPORT_START_RST = 8'd126;
	localparam logic [BYTE_W-1:0]  POLL_ID_RST     = 8'd0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POLL2,
		ST_DUMP_RD,
		ST_DUMP_WR
	} state_t;

	typedef struct packed {
		logic [PROTO_W-1:0] protocol;
		logic [BYTE_W-1:0]  sbus_start;
		logic [BYTE_W-1:0]  sport_start;
		logic [BYTE_W-1:0]  poll_id;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] data;
		logic [IDX_W-1:0]  index;
		logic              last;
		logic              stop;
	} res_t;

endpackage
`default_nettype wire

FILE: src/sfc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_ram - generic simple dual-port RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module sfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 25
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: src/sfc_framer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_framer - protocol state and frame dump sequencer
// Tracks line idle, sbus sync and smart port arming, writes frame bytes into
// the frame store and walks the store one byte per read/emit pair on dump.
// ----------------------------------------------------------------------------
module sfc_framer #(
	parameter int FRAME_LEN = sfc_pkg::FRAME_LEN_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire sfc_pkg::cfg_t             cfg,
	input  wire logic                      accept,
	input  wire logic                      mode,
	input  wire logic [sfc_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic                      slot_free,
	output logic                           ready,
	output sfc_pkg::res_t                  res
);

	localparam int PW = $clog2(FRAME_LEN);
	localparam logic [PW-1:0] LAST_IDX = PW'(FRAME_LEN - 1);
	localparam logic [PW:0]   LAST_EXT = (PW+1)'(FRAME_LEN - 1);

	sfc_pkg::state_t state_q, state_d;

	logic                      line_idle_q, line_idle_d;
	logic                      synced_q, synced_d;
	logic [PW-1:0]             pos_q, pos_d;
	logic [PW-1:0]             idx_q, idx_d;
	logic                      armed_q, armed_d;
	logic [sfc_pkg::BYTE_W-1:0] armed_byte_q, armed_byte_d;
	logic [sfc_pkg::BYTE_W-1:0] pend_q, pend_d;

	logic [PW:0]               pos_inc;
	logic                      ram_we;
	logic [PW-1:0]             ram_waddr;
	logic                      ram_re;
	logic [sfc_pkg::BYTE_W-1:0] ram_rdata;

	assign pos_inc = (PW+1)'(pos_q) + (PW+1)'(1);
	assign ready   = (state_q == sfc_pkg::ST_IDLE) && slot_free;

	sfc_ram #(
		.WIDTH(sfc_pkg::BYTE_W),
		.DEPTH(FRAME_LEN)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(rx_byte),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sfc_pkg::ST_IDLE;
			line_idle_q <= 1'b1;
			synced_q    <= 1'b0;
			pos_q       <= '0;
			idx_q       <= '0;
			armed_q     <= 1'b0;
		end else begin
			state_q     <= state_d;
			line_idle_q <= line_idle_d;
			synced_q    <= synced_d;
			pos_q       <= pos_d;
			idx_q       <= idx_d;
			armed_q     <= armed_d;
		end
	end

	always_ff @(posedge clk) begin
		armed_byte_q <= armed_byte_d;
		pend_q       <= pend_d;
	end

	always_comb begin
		state_d      = state_q;
		line_idle_d  = line_idle_q;
		synced_d     = synced_q;
		pos_d        = pos_q;
		idx_d        = idx_q;
		armed_d      = armed_q;
		armed_byte_d = armed_byte_q;
		pend_d       = pend_q;
		ram_we       = 1'b0;
		ram_waddr    = '0;
		ram_re       = 1'b0;
		res          = '0;

		unique case (state_q)
			sfc_pkg::ST_IDLE: begin
				if (accept) begin
					if (mode == sfc_pkg::MODE_IDLE) begin
						line_idle_d = 1'b1;
					end else begin
						unique case (cfg.protocol)
							sfc_pkg::PROTO_SBUS: begin
								if (synced_q && !line_idle_q) begin
									ram_we = 1'b1;
									if (pos_inc >= LAST_EXT) begin
										// frame full: drop sync and dump the store
										ram_waddr = LAST_IDX;
										synced_d  = 1'b0;
										pos_d     = '0;
										idx_d     = '0;
										state_d   = sfc_pkg::ST_DUMP_RD;
									end else begin
										ram_waddr = pos_inc[PW-1:0];
										pos_d     = pos_inc[PW-1:0];
									end
								end else begin
									// an idle gap mid-frame drops sync here
									synced_d = 1'b0;
									if (line_idle_q && rx_byte == cfg.sbus_start) begin
										synced_d    = 1'b1;
										pos_d       = '0;
										ram_we      = 1'b1;
										ram_waddr   = '0;
										line_idle_d = 1'b0;
									end
								end
							end
							sfc_pkg::PROTO_SPORT: begin
								if (armed_q) begin
									armed_d = 1'b0;
									if (rx_byte == cfg.poll_id) begin
										res.valid    = 1'b1;
										res.kind     = sfc_pkg::KIND_SPORT;
										res.data     = armed_byte_q;
										res.index    = '0;
										res.last     = 1'b0;
										res.stop     = 1'b1;
										pend_d       = rx_byte;
										armed_byte_d = '0;
										state_d      = sfc_pkg::ST_POLL2;
									end
								end else if (line_idle_q && rx_byte == cfg.sport_start) begin
									armed_d      = 1'b1;
									armed_byte_d = rx_byte;
									line_idle_d  = 1'b0;
								end
							end
							sfc_pkg::PROTO_RAW: begin
								res.valid = 1'b1;
								res.kind  = sfc_pkg::KIND_RAW;
								res.data  = rx_byte;
								res.index = '0;
								res.last  = 1'b1;
								res.stop  = 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
			end
			sfc_pkg::ST_POLL2: begin
				if (slot_free) begin
					res.valid = 1'b1;
					res.kind  = sfc_pkg::KIND_SPORT;
					res.data  = pend_q;
					res.index = sfc_pkg::IDX_W'(1);
					res.last  = 1'b1;
					res.stop  = 1'b1;
					state_d   = sfc_pkg::ST_IDLE;
				end
			end
			sfc_pkg::ST_DUMP_RD: begin
				ram_re  = 1'b1;
				state_d = sfc_pkg::ST_DUMP_WR;
			end
			sfc_pkg::ST_DUMP_WR: begin
				// read data holds until the output slot frees up
				if (slot_free) begin
					res.valid = 1'b1;
					res.kind  = sfc_pkg::KIND_SBUS;
					res.data  = ram_rdata;
					res.index = sfc_pkg::IDX_W'(idx_q);
					res.last  = (idx_q == LAST_IDX);
					res.stop  = 1'b0;
					if (idx_q == LAST_IDX) begin
						idx_d   = '0;
						state_d = sfc_pkg::ST_IDLE;
					end else begin
						idx_d   = idx_q + PW'(1);
						state_d = sfc_pkg::ST_DUMP_RD;
					end
				end
			end
			default: begin
				state_d = sfc_pkg::ST_IDLE;
			end
		endcase
	end

	a_res_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> slot_free)
		else $error("result request without a free output slot");

	a_rd_then_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sfc_pkg::ST_DUMP_RD) |=> (state_q == sfc_pkg::ST_DUMP_WR))
		else $error("dump read not followed by emit");

	a_dump_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sfc_pkg::ST_DUMP_WR && slot_free && idx_q == LAST_IDX)
		|=> (state_q == sfc_pkg::ST_IDLE && !synced_q))
		else $error("dump did not end after the last byte");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		synced_q |-> (pos_q < LAST_IDX))
		else $error("frame position past the last byte while synced");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (state_q == sfc_pkg::ST_IDLE))
		else $error("request taken while the sequencer is busy");

endmodule
`default_nettype wire

FILE: src/serial_frame_capture.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_capture - receive framer for a serial line
// Item channel: item_valid/item_stall carry a byte (mode 0) or a line-idle
// event (mode 1). Result channel: result_valid/result_stall carry emitted
// bytes with kind, frame index, last and stop_receive flags.
// Configuration: cfg_we/cfg_index/cfg_data write protocol, sbus start byte,
// smart port start byte and poll id; write only while the block is idle.
// An item with at most one result is taken when the output slot is free; its
// result sits in the output register the cycle after. A smart port poll match
// emits its second byte after the first, once the output slot is free. A
// completed sbus frame is dumped from the frame store byte by byte (store
// read, then emit); no item is taken meanwhile. A stalled receiver holds the
// output register and holds the sequencer at its next emit; the item channel
// stalls while the sequencer is busy or the output slot cannot be refilled.
// Reset: line idle, unsynced, unarmed, registers at their reset values. The
// frame store needs no clearing pass; every byte dumped is written first.
// ----------------------------------------------------------------------------
module serial_frame_capture #(
	parameter int FRAME_LEN = sfc_pkg::FRAME_LEN_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [sfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sfc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic                          mode,
	input  wire logic [sfc_pkg::BYTE_W-1:0]     rx_byte,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic      [sfc_pkg::KIND_W-1:0]     out_kind,
	output logic      [sfc_pkg::BYTE_W-1:0]     out_byte,
	output logic      [sfc_pkg::IDX_W-1:0]      byte_index,
	output logic                               last,
	output logic                               stop_receive
);

	sfc_pkg::cfg_t cfg_q;
	sfc_pkg::res_t res;
	logic          slot_free;
	logic          ready;
	logic          accept;
	logic          result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.protocol    <= sfc_pkg::PROTOCOL_RST;
			cfg_q.sbus_start  <= sfc_pkg::SBUS_START_RST;
			cfg_q.sport_start <= sfc_pkg::SPORT_START_RST;
			cfg_q.poll_id     <= sfc_pkg::POLL_ID_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfc_pkg::CFG_PROTOCOL:    cfg_q.protocol    <= cfg_data[sfc_pkg::PROTO_W-1:0];
				sfc_pkg::CFG_SBUS_START:  cfg_q.sbus_start  <= cfg_data;
				sfc_pkg::CFG_SPORT_START: cfg_q.sport_start <= cfg_data;
				sfc_pkg::CFG_POLL_ID:     cfg_q.poll_id     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign slot_free  = !result_valid_q || !result_stall;
	assign item_stall = !ready;
	assign accept     = item_valid && ready;

	sfc_framer #(
		.FRAME_LEN(FRAME_LEN)
	) u_framer (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.accept   (accept),
		.mode     (mode),
		.rx_byte  (rx_byte),
		.slot_free(slot_free),
		.ready    (ready),
		.res      (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (slot_free) begin
			result_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && res.valid) begin
			out_kind     <= res.kind;
			out_byte     <= res.data;
			byte_index   <= res.index;
			last         <= res.last;
			stop_receive <= res.stop;
		end
	end

	assign result_valid = result_valid_q;

endmodule
`default_nettype wire

FILE: dv/sfc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_checker - result predictor and scoreboard for serial_frame_capture
// Watches the configuration port, the item channel and the result channel.
// Every accepted item runs through a local model of the framer; the bytes it
// emits wait in order and are compared field by field with the results.
// ----------------------------------------------------------------------------
module sfc_checker
	import sfc_pkg::*;
#(
	parameter int FRAME_LEN = FRAME_LEN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  item_valid,
	input  logic                  item_stall,
	input  logic                  mode,
	input  logic [BYTE_W-1:0]     rx_byte,
	input  logic                  result_valid,
	input  logic                  result_stall,
	input  logic [KIND_W-1:0]     out_kind,
	input  logic [BYTE_W-1:0]     out_byte,
	input  logic [IDX_W-1:0]      byte_index,
	input  logic                  last,
	input  logic                  stop_receive,
	output int                    errors,
	output int                    pending,
	output int                    bytes_checked
);

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] data;
		logic [IDX_W-1:0]  index;
		logic              last;
		logic              stop;
	} emitted_t;

	emitted_t awaited_bytes[$];

	int mismatch_total = 0;
	int pending_total  = 0;
	int checked_total  = 0;

	assign errors        = mismatch_total;
	assign pending       = pending_total;
	assign bytes_checked = checked_total;

	// configuration copy
	logic [PROTO_W-1:0] proto_sel;
	logic [BYTE_W-1:0]  sbus_open;
	logic [BYTE_W-1:0]  sport_open;
	logic [BYTE_W-1:0]  poll_match;

	// framer state
	logic              line_quiet;
	logic              in_frame;
	int                frame_pos;
	logic [BYTE_W-1:0] frame_bytes [FRAME_LEN];
	logic              poll_ready;
	logic [BYTE_W-1:0] poll_start;

	task automatic await_byte(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] d,
			input int idx, input logic l, input logic s);
		emitted_t e;
		e.kind  = k;
		e.data  = d;
		e.index = IDX_W'(idx);
		e.last  = l;
		e.stop  = s;
		awaited_bytes.push_back(e);
	endtask

	// advance the framer by one event and queue whatever it emits
	task automatic capture_event(input logic m, input logic [BYTE_W-1:0] b);
		if (m == MODE_IDLE) begin
			line_quiet = 1'b1;
			return;
		end
		case (proto_sel)
			PROTO_SBUS: begin
				// a gap seen mid-frame drops sync; the same byte may reopen
				if (line_quiet)
					in_frame = 1'b0;
				if (in_frame) begin
					if (frame_pos < FRAME_LEN - 1)
						frame_pos++;
					frame_bytes[frame_pos] = b;
					if (frame_pos == FRAME_LEN - 1) begin
						for (int i = 0; i < FRAME_LEN; i++)
							await_byte(KIND_SBUS, frame_bytes[i], i, i == FRAME_LEN - 1, 1'b0);
						in_frame  = 1'b0;
						frame_pos = 0;
					end
				end else if (b == sbus_open && line_quiet) begin
					in_frame       = 1'b1;
					frame_pos      = 0;
					frame_bytes[0] = b;
					line_quiet     = 1'b0;
				end
			end
			PROTO_SPORT: begin
				if (poll_ready) begin
					if (b == poll_match) begin
						await_byte(KIND_SPORT, poll_start, 0, 1'b0, 1'b1);
						await_byte(KIND_SPORT, b, 1, 1'b1, 1'b1);
						poll_start = '0;
					end
					poll_ready = 1'b0;
				end else if (b == sport_open && line_quiet) begin
					poll_ready = 1'b1;
					poll_start = b;
					line_quiet = 1'b0;
				end
			end
			PROTO_RAW:
				await_byte(KIND_RAW, b, 0, 1'b1, 1'b0);
			default: ;
		endcase
	endtask

	task automatic check_result();
		emitted_t want;
		if (awaited_bytes.size() == 0) begin
			mismatch_total++;
			if (mismatch_total <= 10)
				$display("[%0t] unexpected output: kind=%0d byte=%02h idx=%0d last=%0d stop=%0d",
					$time, out_kind, out_byte, byte_index, last, stop_receive);
			return;
		end
		want = awaited_bytes.pop_front();
		checked_total++;
		if (out_kind !== want.kind || out_byte !== want.data || byte_index !== want.index ||
				last !== want.last || stop_receive !== want.stop) begin
			mismatch_total++;
			if (mismatch_total <= 10) begin
				$display("[%0t] output mismatch: expected kind=%0d byte=%02h idx=%0d last=%0d stop=%0d",
					$time, want.kind, want.data, want.index, want.last, want.stop);
				$display("[%0t]                  actual   kind=%0d byte=%02h idx=%0d last=%0d stop=%0d",
					$time, out_kind, out_byte, byte_index, last, stop_receive);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proto_sel  = PROTOCOL_RST;
			sbus_open  = SBUS_START_RST;
			sport_open = SPORT_START_RST;
			poll_match = POLL_ID_RST;
			line_quiet = 1'b1;
			in_frame   = 1'b0;
			frame_pos  = 0;
			poll_ready = 1'b0;
			poll_start = '0;
			awaited_bytes.delete();
			pending_total = 0;
		end else begin
			// results can only come from earlier requests, so check first
			if (result_valid && !result_stall)
				check_result();
			if (item_valid && !item_stall)
				capture_event(mode, rx_byte);
			if (cfg_we) begin
				case (cfg_index)
					CFG_PROTOCOL:    proto_sel  = cfg_data[PROTO_W-1:0];
					CFG_SBUS_START:  sbus_open  = cfg_data[BYTE_W-1:0];
					CFG_SPORT_START: sport_open = cfg_data[BYTE_W-1:0];
					CFG_POLL_ID:     poll_match = cfg_data[BYTE_W-1:0];
					default: ;
				endcase
			end
			pending_total = awaited_bytes.size();
		end
	end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench top for serial_frame_capture
// Drives short directed sequences and then protocol-aware random traffic
// (full sbus frames, interrupted frames, smart port polls, raw bytes, noise)
// through several register settings and three idling profiles. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import sfc_pkg::*;

	localparam int FRAME_LEN   = FRAME_LEN_DEF;
	localparam int SETTLE      = 2 * FRAME_LEN + 8;
	localparam int CYCLE_LIMIT = 600000;

	// protocol code that selects no framer at all
	localparam logic [PROTO_W-1:0] PROTO_OFF = 2'd3;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  item_valid   = 1'b0;
	logic                  mode         = MODE_BYTE;
	logic [BYTE_W-1:0]     rx_byte      = '0;
	logic                  result_stall = 1'b0;
	logic                  item_stall;
	logic                  result_valid;
	logic [KIND_W-1:0]     out_kind;
	logic [BYTE_W-1:0]     out_byte;
	logic [IDX_W-1:0]      byte_index;
	logic                  last;
	logic                  stop_receive;

	int errors;
	int pending;
	int bytes_checked;

	int send_gap_pct = 13;
	int stall_pct    = 56;
	int items_sent   = 0;
	int cycles       = 0;

	logic [PROTO_W-1:0] cur_proto = PROTOCOL_RST;
	logic [BYTE_W-1:0]  cur_sbus  = SBUS_START_RST;
	logic [BYTE_W-1:0]  cur_sport = SPORT_START_RST;
	logic [BYTE_W-1:0]  cur_poll  = POLL_ID_RST;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	serial_frame_capture #(.FRAME_LEN(FRAME_LEN)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.mode         (mode),
		.rx_byte      (rx_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_kind     (out_kind),
		.out_byte     (out_byte),
		.byte_index   (byte_index),
		.last         (last),
		.stop_receive (stop_receive)
	);

	sfc_checker #(.FRAME_LEN(FRAME_LEN)) frame_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.mode          (mode),
		.rx_byte       (rx_byte),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.out_kind      (out_kind),
		.out_byte      (out_byte),
		.byte_index    (byte_index),
		.last          (last),
		.stop_receive  (stop_receive),
		.errors        (errors),
		.pending       (pending),
		.bytes_checked (bytes_checked)
	);

	always @(negedge clk) begin
		result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d output bytes still pending", cycles, pending);
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(0, 15))
			0: return 8'h00;
			1: return 8'hFF;
			default: return BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input logic m, input logic [BYTE_W-1:0] b);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		mode       = m;
		rx_byte    = b;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		send_item(MODE_BYTE, b);
	endtask

	task automatic send_gap();
		send_item(MODE_IDLE, pick_byte());
	endtask

	task automatic wait_quiet();
		item_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = d;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [PROTO_W-1:0] p, input logic [BYTE_W-1:0] sb,
			input logic [BYTE_W-1:0] sp, input logic [BYTE_W-1:0] pid);
		wait_quiet();
		write_reg(CFG_PROTOCOL, CFG_DATA_W'(p));
		write_reg(CFG_SBUS_START, sb);
		write_reg(CFG_SPORT_START, sp);
		write_reg(CFG_POLL_ID, pid);
		cfg_we    = 1'b0;
		cur_proto = p;
		cur_sbus  = sb;
		cur_sport = sp;
		cur_poll  = pid;
	endtask

	task automatic random_events(input int count);
		int stop_at;
		int r;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			r = $urandom_range(0, 99);
			case (cur_proto)
				PROTO_SBUS: begin
					if (r < 70) begin
						send_gap();
						send_byte(cur_sbus);
						repeat (FRAME_LEN - 1) send_byte(pick_byte());
					end else if (r < 85) begin
						// frame cut short by a line gap
						send_gap();
						send_byte(cur_sbus);
						repeat ($urandom_range(0, FRAME_LEN - 5)) send_byte(pick_byte());
						send_gap();
						if ($urandom_range(0, 1)) begin
							send_byte(cur_sbus);
							repeat (FRAME_LEN - 1) send_byte(pick_byte());
						end else begin
							send_byte(pick_byte());
						end
					end else if (r < 92) begin
						send_byte(cur_sbus);
					end else begin
						send_item($urandom_range(0, 3) == 0 ? MODE_IDLE : MODE_BYTE, pick_byte());
					end
				end
				PROTO_SPORT: begin
					if (r < 55) begin
						send_gap();
						send_byte(cur_sport);
						if ($urandom_range(0, 4) == 0)
							send_gap();
						send_byte(cur_poll);
					end else if (r < 75) begin
						send_gap();
						send_byte(cur_sport);
						send_byte(pick_byte());
					end else if (r < 85) begin
						send_byte(cur_sport);
					end else begin
						send_item($urandom_range(0, 3) == 0 ? MODE_IDLE : MODE_BYTE, pick_byte());
					end
				end
				default:
					send_item(r < 15 ? MODE_IDLE : MODE_BYTE, pick_byte());
			endcase
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: frame with a gap mid-way, extreme bytes, reopened by the start byte
		send_gap();
		send_byte(8'd15);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_gap();
		send_byte(8'd15);
		send_byte(8'hAA);
		send_byte(8'h55);
		send_byte(8'd15);
		// leave the frame open across raw and disabled protocols, then finish it
		set_config(PROTO_RAW, 8'd15, 8'd126, 8'd0);
		send_byte(8'h00);
		send_byte(8'hFF);
		set_config(PROTO_OFF, 8'd15, 8'd126, 8'd0);
		send_byte(8'hC3);
		set_config(PROTO_SBUS, 8'd15, 8'd126, 8'd0);
		for (int i = 0; i < FRAME_LEN - 4; i++)
			send_byte(i == 0 ? 8'hFF : i == FRAME_LEN - 5 ? 8'h00 : BYTE_W'(i * 37 + 5));
		// smart port: match, start with no gap, gap between start and poll, mismatch
		set_config(PROTO_SPORT, 8'd15, 8'd126, 8'd0);
		send_gap();
		send_byte(8'd126);
		send_byte(8'd0);
		send_byte(8'd126);
		send_byte(8'd0);
		send_gap();
		send_byte(8'd126);
		send_gap();
		send_byte(8'd0);
		send_gap();
		send_byte(8'd126);
		send_byte(8'd126);

		set_config(PROTO_SBUS, 8'h00, 8'hFF, 8'hFF);
		random_events(55);
		set_config(PROTO_SPORT, 8'hFF, 8'h00, 8'h00);
		random_events(35);
		set_config(PROTO_RAW, pick_byte(), pick_byte(), pick_byte());
		random_events(25);

		send_gap_pct = 56;
		stall_pct    = 13;
		set_config(PROTO_SBUS, 8'hFF, pick_byte(), pick_byte());
		random_events(55);
		cur_sport = pick_byte();
		set_config(PROTO_SPORT, pick_byte(), cur_sport, cur_sport);
		random_events(40);
		set_config(PROTO_OFF, pick_byte(), pick_byte(), pick_byte());
		random_events(10);

		send_gap_pct = 0;
		stall_pct    = 0;
		set_config(PROTO_SBUS, pick_byte(), pick_byte(), pick_byte());
		random_events(65);
		set_config(PROTO_SPORT, pick_byte(), pick_byte(), pick_byte());
		random_events(30);
		set_config(PROTO_RAW, 8'h00, 8'hFF, 8'hFF);
		random_events(25);

		wait_quiet();
		$display("covered %0d line events over sbus, smart port, raw and disabled settings",
			items_sent);
		$display("%0d output bytes compared, %0d mismatches", bytes_checked, errors);
		if (errors == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
